// ===== hdl/assert_macros.svh =====
// Assertion macros used by the block's controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define AVD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define AVD_ASSERT(lbl, prop)
`define AVD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/avd_pkg.sv =====
// Types, constants and control structs of the VWAP deviation alert block.
package avd_pkg;

  localparam int unsigned NUM_AGENTS_DEF = 1024;

  localparam int unsigned MUL_AW = 128;
  localparam int unsigned MUL_BW = 64;
  localparam int unsigned MUL_PW = 160;
  localparam int unsigned DIV_NW = 160;
  localparam int unsigned DIV_DW = 112;
  localparam int unsigned DIV_CW = $clog2(DIV_NW);

  localparam logic [1:0]  TT_BUY      = 2'd2;
  localparam logic [1:0]  TT_SELL     = 2'd3;
  localparam logic [23:0] VOL_THR_RST = 24'd500;
  localparam logic [19:0] DEV_THR_RST = 20'd1000;
  localparam logic [19:0] PPM_SCALE   = 20'd1000000;

  typedef enum logic [1:0] {
    CFG_VOL_THR = 2'd0,
    CFG_DEV_THR = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MS_X = 2'd0,
    MS_Y = 2'd1,
    MS_D = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    DS_DAY = 2'd0,
    DS_DEV = 2'd1,
    DS_AVG = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic [23:0] price;
    logic [23:0] qty;
    logic [1:0]  trade_kind;
    logic [9:0]  buyer_id;
    logic [9:0]  seller_id;
  } trade_t;

  typedef struct packed {
    logic [9:0]  alert_agent;
    logic        side;
    logic [23:0] trade_price;
    logic [31:0] agent_average;
    logic [31:0] day_average;
    logic [47:0] agent_volume;
    logic [23:0] deviation_ppm;
  } alert_t;

  typedef struct packed {
    logic     clr_wr;
    logic     in_load;
    logic     note_load;
    logic     upd;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     x_load;
    logic     y_load;
    logic     side_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     dday_load;
    logic     ddev_load;
    logic     davg_load;
    logic     zero_agent;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic agent_ok;
    logic agent_pass;
    logic aq_zero;
    logic dev_pass;
    logic mul_busy;
    logic mul_done;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/avd_mul.sv =====
// Sequential wide multiplier built from 32x32 partial products.
module avd_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [avd_pkg::MUL_AW-1:0]    a_i,
  input  logic [avd_pkg::MUL_BW-1:0]    b_i,
  output logic [avd_pkg::MUL_PW-1:0]    p_o,
  output logic                          busy_o,
  output logic                          done_o
);

  logic [avd_pkg::MUL_AW-1:0] a_q;
  logic [avd_pkg::MUL_BW-1:0] b_q;
  logic [avd_pkg::MUL_PW-1:0] acc_q;
  logic [63:0]                pp_q, pp_d;
  logic [2:0]                 step_q, sh_q, sh_d;
  logic                       issue_q, pv_q, plast_q, done_q;

  assign pp_d = 64'(a_q[{step_q[2:1], 5'd0} +: 32]) * 64'(b_q[{step_q[0], 5'd0} +: 32]);
  assign sh_d = {1'b0, step_q[2:1]} + {2'b00, step_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= 3'd0;
    end else begin
      done_q  <= pv_q & plast_q;
      pv_q    <= issue_q;
      plast_q <= issue_q && (step_q == 3'd7);
      if (start_i) begin
        issue_q <= 1'b1;
        step_q  <= 3'd0;
      end else if (issue_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
    sh_q <= sh_d;
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + (avd_pkg::MUL_PW'(pp_q) << {sh_q, 5'd0});
    end
  end

  assign p_o    = acc_q;
  assign busy_o = issue_q | pv_q;
  assign done_o = done_q;

endmodule

// ===== hdl/avd_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit quotient with overflow flag.
module avd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [avd_pkg::DIV_NW-1:0]  n_i,
  input  logic [avd_pkg::DIV_DW-1:0]  d_i,
  output logic [31:0]                 q_o,
  output logic                        ovf_o,
  output logic                        busy_o,
  output logic                        done_o
);

  logic [avd_pkg::DIV_NW-1:0] n_q;
  logic [avd_pkg::DIV_DW-1:0] d_q, rem_q;
  logic [avd_pkg::DIV_DW:0]   r, rn;
  logic [31:0]                q_q;
  logic                       ovf_q, ge;
  logic [avd_pkg::DIV_CW-1:0] cnt_q;
  logic                       run_q, done_q;

  assign r  = {rem_q, n_q[avd_pkg::DIV_NW-1]};
  assign ge = r >= {1'b0, d_q};
  assign rn = ge ? r - {1'b0, d_q} : r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= avd_pkg::DIV_CW'(avd_pkg::DIV_NW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      d_q   <= d_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      n_q   <= n_q << 1;
      rem_q <= rn[avd_pkg::DIV_DW-1:0];
      q_q   <= {q_q[30:0], ge};
      ovf_q <= ovf_q | q_q[31];
    end
  end

  assign q_o    = q_q;
  assign ovf_o  = ovf_q;
  assign busy_o = run_q;
  assign done_o = done_q;

endmodule

// ===== hdl/avd_dp.sv =====
// Datapath: day totals, agent table, cross products, divisions and result register.
module avd_dp #(
  parameter int unsigned NUM_AGENTS = avd_pkg::NUM_AGENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  avd_pkg::ctrl_cmd_t cmd_i,
  output avd_pkg::dp_sts_t   sts_o,
  input  avd_pkg::trade_t    in_item_i,
  input  logic [23:0]        vol_thr_i,
  input  logic [19:0]        dev_thr_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output avd_pkg::alert_t    out_item_o
);

  localparam int unsigned AW = $clog2(NUM_AGENTS);

  logic [111:0] mem_q [NUM_AGENTS];

  avd_pkg::trade_t trade_q;
  avd_pkg::alert_t out_q;
  logic [47:0]  notional_q, dv_q, aq_q;
  logic [63:0]  dn_q, an_q;
  logic [111:0] rd_q, x_q, y_q, diff;
  logic [AW-1:0] clr_q, addr, wa;
  logic         side_q, out_valid_q, x_ge_y;
  logic [31:0]  dday_q, davg_q;
  logic [23:0]  dev_q, dev_sat;
  logic [31:0]  avg_sat;
  logic [9:0]   id;
  logic         agent_ok, we;
  logic [111:0] wd;
  logic [64:0]  dn_sum, an_sum;
  logic [48:0]  dv_sum, aq_sum;
  logic [63:0]  dn_new, an_new;
  logic [47:0]  dv_new, aq_new;

  logic [avd_pkg::MUL_AW-1:0] mul_a;
  logic [avd_pkg::MUL_BW-1:0] mul_b;
  logic [avd_pkg::MUL_PW-1:0] mul_p;
  logic                       mul_busy, mul_done;
  logic [avd_pkg::DIV_NW-1:0] div_n;
  logic [avd_pkg::DIV_DW-1:0] div_d;
  logic [31:0]                div_q;
  logic                       div_ovf, div_busy, div_done;

  assign id = (trade_q.trade_kind == avd_pkg::TT_BUY) ? trade_q.buyer_id : trade_q.seller_id;
  assign agent_ok = ((trade_q.trade_kind == avd_pkg::TT_BUY) ||
                     (trade_q.trade_kind == avd_pkg::TT_SELL)) &&
                    (32'(id) < NUM_AGENTS);
  assign addr = AW'(id);

  // saturating accumulators
  assign dn_sum = {1'b0, dn_q} + 65'(notional_q);
  assign dv_sum = {1'b0, dv_q} + 49'(trade_q.qty);
  assign an_sum = {1'b0, rd_q[111:48]} + 65'(notional_q);
  assign aq_sum = {1'b0, rd_q[47:0]} + 49'(trade_q.qty);
  assign dn_new = dn_sum[64] ? '1 : dn_sum[63:0];
  assign dv_new = dv_sum[48] ? '1 : dv_sum[47:0];
  assign an_new = an_sum[64] ? '1 : an_sum[63:0];
  assign aq_new = aq_sum[48] ? '1 : aq_sum[47:0];

  assign we = cmd_i.clr_wr | (cmd_i.upd & agent_ok);
  assign wa = cmd_i.clr_wr ? clr_q : addr;
  assign wd = cmd_i.clr_wr ? '0 : {an_new, aq_new};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (cmd_i.note_load) begin
      rd_q <= mem_q[addr];
    end
  end

  assign x_ge_y = x_q >= y_q;
  assign diff   = x_ge_y ? x_q - y_q : y_q - x_q;

  always_comb begin
    case (cmd_i.mul_sel)
      avd_pkg::MS_X: begin
        mul_a = avd_pkg::MUL_AW'(an_q);
        mul_b = avd_pkg::MUL_BW'(dv_q);
      end
      avd_pkg::MS_Y: begin
        mul_a = avd_pkg::MUL_AW'(dn_q);
        mul_b = avd_pkg::MUL_BW'(aq_q);
      end
      avd_pkg::MS_D: begin
        mul_a = avd_pkg::MUL_AW'(diff);
        mul_b = avd_pkg::MUL_BW'(avd_pkg::PPM_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.div_sel)
      avd_pkg::DS_DAY: begin
        div_n = avd_pkg::DIV_NW'({dn_q, 8'd0});
        div_d = avd_pkg::DIV_DW'(dv_q);
      end
      avd_pkg::DS_DEV: begin
        div_n = mul_p;
        div_d = y_q;
      end
      avd_pkg::DS_AVG: begin
        div_n = avd_pkg::DIV_NW'({an_q, 8'd0});
        div_d = avd_pkg::DIV_DW'(aq_q);
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  avd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .p_o     (mul_p),
    .busy_o  (mul_busy),
    .done_o  (mul_done)
  );

  avd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .q_o     (div_q),
    .ovf_o   (div_ovf),
    .busy_o  (div_busy),
    .done_o  (div_done)
  );

  assign avg_sat = div_ovf ? '1 : div_q;
  assign dev_sat = (div_ovf || (div_q[31:24] != 8'd0)) ? '1 : div_q[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_q        <= '0;
      dv_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.upd) begin
        dn_q <= dn_new;
        dv_q <= dv_new;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      trade_q <= in_item_i;
    end
    if (cmd_i.note_load) begin
      notional_q <= 48'(trade_q.price) * 48'(trade_q.qty);
    end
    if (cmd_i.upd) begin
      an_q <= an_new;
      aq_q <= aq_new;
    end
    if (cmd_i.x_load) begin
      x_q <= mul_p[111:0];
    end
    if (cmd_i.y_load) begin
      y_q <= mul_p[111:0];
    end
    if (cmd_i.side_load) begin
      side_q <= x_ge_y;
    end
    if (cmd_i.dday_load) begin
      dday_q <= avg_sat;
    end
    if (cmd_i.ddev_load) begin
      dev_q <= dev_sat;
    end
    if (cmd_i.davg_load) begin
      davg_q <= avg_sat;
    end
    if (cmd_i.zero_agent) begin
      davg_q <= '0;
      dev_q  <= 24'(avd_pkg::PPM_SCALE);
      side_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_q.alert_agent   <= id;
      out_q.side          <= side_q;
      out_q.trade_price   <= trade_q.price;
      out_q.agent_average <= davg_q;
      out_q.day_average   <= dday_q;
      out_q.agent_volume  <= aq_q;
      out_q.deviation_ppm <= dev_q;
    end
  end

  assign sts_o.clr_last   = (clr_q == AW'(NUM_AGENTS - 1));
  assign sts_o.agent_ok   = agent_ok;
  assign sts_o.agent_pass = (aq_q >= 48'(vol_thr_i)) && (dn_q != '0);
  assign sts_o.aq_zero    = (aq_q == '0);
  assign sts_o.dev_pass   = (dev_q >= 24'(dev_thr_i));
  assign sts_o.mul_busy   = mul_busy;
  assign sts_o.mul_done   = mul_done;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/avd_ctrl.sv =====
// Controller: sequences table clear, update, multiplies and divisions per item.
`include "assert_macros.svh"

module avd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  avd_pkg::dp_sts_t   sts_i,
  output avd_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_NOTE  = 13'b0000000000100,
    S_UPD   = 13'b0000000001000,
    S_CHK   = 13'b0000000010000,
    S_DDAY  = 13'b0000000100000,
    S_MULX  = 13'b0000001000000,
    S_MULY  = 13'b0000010000000,
    S_DIFF  = 13'b0000100000000,
    S_MULD  = 13'b0001000000000,
    S_DDEV  = 13'b0010000000000,
    S_DAVG  = 13'b0100000000000,
    S_THR   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_NOTE;
        end
      end
      S_NOTE: begin
        cmd_o.note_load = 1'b1;
        state_d         = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.agent_ok ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (sts_i.agent_pass) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = avd_pkg::DS_DAY;
          state_d         = S_DDAY;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DDAY: begin
        if (sts_i.div_done) begin
          cmd_o.dday_load = 1'b1;
          if (sts_i.aq_zero) begin
            cmd_o.zero_agent = 1'b1;
            state_d          = S_THR;
          end else begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = avd_pkg::MS_X;
            state_d         = S_MULX;
          end
        end
      end
      S_MULX: begin
        if (sts_i.mul_done) begin
          cmd_o.x_load    = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = avd_pkg::MS_Y;
          state_d         = S_MULY;
        end
      end
      S_MULY: begin
        if (sts_i.mul_done) begin
          cmd_o.y_load = 1'b1;
          state_d      = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.side_load = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = avd_pkg::MS_D;
        state_d         = S_MULD;
      end
      S_MULD: begin
        if (sts_i.mul_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = avd_pkg::DS_DEV;
          state_d         = S_DDEV;
        end
      end
      S_DDEV: begin
        if (sts_i.div_done) begin
          cmd_o.ddev_load = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = avd_pkg::DS_AVG;
          state_d         = S_DAVG;
        end
      end
      S_DAVG: begin
        if (sts_i.div_done) begin
          cmd_o.davg_load = 1'b1;
          state_d         = S_THR;
        end
      end
      S_THR: begin
        if (!sts_i.dev_pass) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `AVD_ASSERT(a_mul_idle, cmd_o.mul_start |-> !sts_i.mul_busy)
  `AVD_ASSERT(a_div_idle, cmd_o.div_start |-> !sts_i.div_busy)
  `AVD_ASSERT(a_no_overwrite, cmd_o.out_load |-> sts_i.out_free)
  `AVD_ASSERT_ALWAYS(a_rst_closed, !rst_ni |-> !in_ready_o)

endmodule

// ===== hdl/agent_vwap_deviation_alert_top.sv =====
// Top level of the agent VWAP deviation alert block.
//
// Trades enter on in_valid_i/in_ready_o as avd_pkg::trade_t items; alerts leave
// on out_valid_o/out_ready_i as avd_pkg::alert_t items, at most one per trade.
// Thresholds are written on cfg_valid_i/cfg_ready_o (index 0 volume threshold,
// index 1 deviation threshold in ppm); writes are always taken.
// After reset the agent table is cleared, one entry a cycle; no trade is
// taken during that pass. A trade that only updates the day totals returns to
// idle after the update; an agent trade may stop at the volume check, and one
// with zero agent quantity after the day division. A trade that reaches the
// deviation test runs three serial divisions and three partial-product
// multiplies.
// One trade is in work at a time. A finished alert sits in the output register
// while the next trade is taken; if the receiver still stalls when a further
// alert is ready, the block waits until that register is freed.
module agent_vwap_deviation_alert_top #(
  parameter int unsigned NUM_AGENTS = avd_pkg::NUM_AGENTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  avd_pkg::trade_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output avd_pkg::alert_t out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [23:0]     cfg_data_i
);

  avd_pkg::ctrl_cmd_t cmd;
  avd_pkg::dp_sts_t   sts;
  logic [23:0]        vol_thr_q;
  logic [19:0]        dev_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_thr_q <= avd_pkg::VOL_THR_RST;
      dev_thr_q <= avd_pkg::DEV_THR_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == avd_pkg::CFG_VOL_THR) begin
        vol_thr_q <= cfg_data_i;
      end else if (cfg_index_i == avd_pkg::CFG_DEV_THR) begin
        dev_thr_q <= cfg_data_i[19:0];
      end
    end
  end

  avd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  avd_dp #(
    .NUM_AGENTS (NUM_AGENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .vol_thr_i   (vol_thr_q),
    .dev_thr_i   (dev_thr_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/tb_agent_vwap_deviation_alert_top.sv =====
// Self-checking testbench for the agent VWAP deviation alert block.
module tb_agent_vwap_deviation_alert_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AGENTS    = avd_pkg::NUM_AGENTS_DEF;
  localparam int unsigned SETTLE    = 700;
  localparam int unsigned STALL_MAX = 40000;
  localparam int unsigned HOLD_LEN  = 3000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  avd_pkg::trade_t   in_item;
  logic              out_valid;
  logic              out_ready;
  avd_pkg::alert_t   out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  avd_pkg::cfg_idx_e cfg_index;
  logic [23:0]       cfg_data;

  agent_vwap_deviation_alert_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  avd_pkg::trade_t trade_q[$];
  avd_pkg::alert_t alert_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_cnt;
  int unsigned trade_cnt;
  int unsigned alert_cnt;
  int unsigned wr_cnt;
  int unsigned stall_cnt;
  int unsigned hold_cnt;
  logic        hold_req;
  logic        hold_taken;
  logic        trade_taken;

  logic [63:0] day_not;
  logic [47:0] day_vol;
  logic [63:0] agent_not [AGENTS];
  logic [47:0] agent_vol [AGENTS];
  logic [23:0] vol_thr;
  logic [19:0] dev_thr;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Expected alert for one accepted trade; updates the running totals.
  task automatic predict_alert(input avd_pkg::trade_t t);
    logic [47:0]  notional;
    logic [64:0]  sum64;
    logic [48:0]  sum48;
    logic [9:0]   id;
    logic [63:0]  an;
    logic [47:0]  aq;
    logic [255:0] x, y, diff, q, davg, aavg;
    logic [63:0]  dev;
    logic         side;
    avd_pkg::alert_t a;
    notional = 48'(t.price) * 48'(t.qty);
    sum64 = {1'b0, day_not} + 65'(notional);
    day_not = sum64[64] ? '1 : sum64[63:0];
    sum48 = {1'b0, day_vol} + 49'(t.qty);
    day_vol = sum48[48] ? '1 : sum48[47:0];
    if (t.trade_kind == avd_pkg::TT_BUY) id = t.buyer_id;
    else if (t.trade_kind == avd_pkg::TT_SELL) id = t.seller_id;
    else return;
    sum64 = {1'b0, agent_not[id]} + 65'(notional);
    agent_not[id] = sum64[64] ? '1 : sum64[63:0];
    sum48 = {1'b0, agent_vol[id]} + 49'(t.qty);
    agent_vol[id] = sum48[48] ? '1 : sum48[47:0];
    an = agent_not[id];
    aq = agent_vol[id];
    if (aq < 48'(vol_thr) || day_not == 0 || day_vol == 0) return;
    davg = (256'(day_not) * 256) / 256'(day_vol);
    if (aq == 0) begin
      aavg = 0;
      dev  = 64'(avd_pkg::PPM_SCALE);
      side = 1'b0;
    end else begin
      x    = 256'(an) * 256'(day_vol);
      y    = 256'(day_not) * 256'(aq);
      side = (x < y) ? 1'b0 : 1'b1;
      diff = (x < y) ? y - x : x - y;
      q    = (diff * 256'(avd_pkg::PPM_SCALE)) / y;
      dev  = (q > 256'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : q[63:0];
      aavg = (256'(an) * 256) / 256'(aq);
    end
    if (dev < 64'(dev_thr)) return;
    a.alert_agent   = id;
    a.side          = side;
    a.trade_price   = t.price;
    a.agent_average = (aavg > 256'(32'hFFFF_FFFF)) ? '1 : aavg[31:0];
    a.day_average   = (davg > 256'(32'hFFFF_FFFF)) ? '1 : davg[31:0];
    a.agent_volume  = aq;
    a.deviation_ppm = (dev > 64'hFF_FFFF) ? '1 : dev[23:0];
    alert_q.push_back(a);
  endtask

  // Acceptance, checking and watchdog
  always @(posedge clk) begin
    trade_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (in_valid && in_ready) begin
        trade_cnt++;
        predict_alert(in_item);
      end
      if (out_valid && out_ready) begin
        alert_cnt++;
        if (alert_q.size() == 0) begin
          report("unexpected alert", 64'(out_item.alert_agent), 0);
        end else begin
          avd_pkg::alert_t e;
          e = alert_q.pop_front();
          if (out_item.alert_agent != e.alert_agent)
            report("alert_agent", 64'(out_item.alert_agent), 64'(e.alert_agent));
          if (out_item.side != e.side) report("side", 64'(out_item.side), 64'(e.side));
          if (out_item.trade_price != e.trade_price)
            report("trade_price", 64'(out_item.trade_price), 64'(e.trade_price));
          if (out_item.agent_average != e.agent_average)
            report("agent_average", 64'(out_item.agent_average), 64'(e.agent_average));
          if (out_item.day_average != e.day_average)
            report("day_average", 64'(out_item.day_average), 64'(e.day_average));
          if (out_item.agent_volume != e.agent_volume)
            report("agent_volume", 64'(out_item.agent_volume), 64'(e.agent_volume));
          if (out_item.deviation_ppm != e.deviation_ppm)
            report("deviation_ppm", 64'(out_item.deviation_ppm), 64'(e.deviation_ppm));
        end
      end
      if (stall_cnt >= STALL_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Trade driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || trade_taken)) begin
      if (trade_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= trade_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Alert receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt   <= HOLD_LEN;
        out_ready  <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input avd_pkg::cfg_idx_e idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == avd_pkg::CFG_VOL_THR) vol_thr = val;
    else dev_thr = val[19:0];
    wr_cnt++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (trade_q.size() != 0 || in_valid || alert_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic avd_pkg::trade_t rand_trade();
    avd_pkg::trade_t t;
    int unsigned r;
    r = $urandom_range(99, 0);
    t.price = (r < 10) ? 24'($urandom) : 24'($urandom_range(11000, 9000));
    r = $urandom_range(99, 0);
    if (r < 5) t.qty = 0;
    else if (r < 9) t.qty = 24'($urandom);
    else t.qty = 24'($urandom_range(400, 1));
    r = $urandom_range(99, 0);
    t.trade_kind = (r < 85) ? (r[0] ? avd_pkg::TT_BUY : avd_pkg::TT_SELL) :
                              2'($urandom_range(1, 0));
    t.buyer_id  = ($urandom_range(9, 0) == 0) ? 10'($urandom) : 10'($urandom_range(7, 0));
    t.seller_id = ($urandom_range(9, 0) == 0) ? 10'($urandom) : 10'($urandom_range(7, 0));
    return t;
  endfunction

  function automatic avd_pkg::trade_t mk(input logic [23:0] p, input logic [23:0] q,
                                         input logic [1:0] tt, input logic [9:0] b,
                                         input logic [9:0] s);
    avd_pkg::trade_t t;
    t.price = p; t.qty = q; t.trade_kind = tt; t.buyer_id = b; t.seller_id = s;
    return t;
  endfunction

  task automatic run_phase(input int n, input int unsigned sidle, input int unsigned ridle,
                           input logic [23:0] vthr, input logic [23:0] dthr);
    drain();
    write_reg(avd_pkg::CFG_VOL_THR, vthr);
    write_reg(avd_pkg::CFG_DEV_THR, dthr);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (n) trade_q.push_back(rand_trade());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = avd_pkg::CFG_VOL_THR;
    cfg_data = '0;
    send_idle_pct = 21;
    recv_idle_pct = 85;
    err_cnt = 0; trade_cnt = 0; alert_cnt = 0; wr_cnt = 0;
    stall_cnt = 0; hold_cnt = 0; hold_req = 1'b0; hold_taken = 1'b0;
    day_not = 0; day_vol = 0;
    for (int i = 0; i < AGENTS; i++) begin
      agent_not[i] = 0;
      agent_vol[i] = 0;
    end
    vol_thr = avd_pkg::VOL_THR_RST;
    dev_thr = avd_pkg::DEV_THR_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero day VWAP, equal VWAPs, zero agent quantity, extremes
    write_reg(avd_pkg::CFG_VOL_THR, 24'd0);
    write_reg(avd_pkg::CFG_DEV_THR, 24'd0);
    trade_q.push_back(mk(24'd0, 24'd10, avd_pkg::TT_BUY, 10'd3, 10'd4));
    trade_q.push_back(mk(24'hFF_FFFF, 24'hFF_FFFF, avd_pkg::TT_BUY, 10'd1023, 10'd0));
    trade_q.push_back(mk(24'hFF_FFFF, 24'hFF_FFFF, avd_pkg::TT_SELL, 10'd0, 10'd1023));
    trade_q.push_back(mk(24'd0, 24'hFF_FFFF, avd_pkg::TT_SELL, 10'd1023, 10'd0));
    trade_q.push_back(mk(24'd1, 24'd1, 2'd0, 10'd5, 10'd6));
    trade_q.push_back(mk(24'd12345, 24'd7, 2'd1, 10'h2AA, 10'h155));
    trade_q.push_back(mk(24'd500, 24'd0, avd_pkg::TT_BUY, 10'd9, 10'd10));
    trade_q.push_back(mk(24'd500, 24'd0, avd_pkg::TT_SELL, 10'd11, 10'd12));
    trade_q.push_back(mk(24'd1, 24'd1, avd_pkg::TT_BUY, 10'h155, 10'h2AA));
    trade_q.push_back(mk(24'hFF_FFFF, 24'd1, avd_pkg::TT_SELL, 10'h155, 10'h2AA));
    trade_q.push_back(mk(24'd100, 24'd100, avd_pkg::TT_BUY, 10'd20, 10'd21));
    drain();
    write_reg(avd_pkg::CFG_DEV_THR, 24'hFF_FFFF);
    trade_q.push_back(mk(24'd500, 24'd0, avd_pkg::TT_BUY, 10'd30, 10'd31));
    trade_q.push_back(mk(24'd1, 24'd1000, avd_pkg::TT_SELL, 10'd32, 10'd33));
    drain();
    write_reg(avd_pkg::CFG_DEV_THR, 24'd1000000);
    trade_q.push_back(mk(24'd500, 24'd0, avd_pkg::TT_SELL, 10'd40, 10'd41));
    trade_q.push_back(mk(24'd1, 24'd100000, avd_pkg::TT_BUY, 10'd42, 10'd43));
    drain();
    write_reg(avd_pkg::CFG_VOL_THR, 24'hFF_FFFF);
    write_reg(avd_pkg::CFG_DEV_THR, 24'd0);
    trade_q.push_back(mk(24'd9000, 24'd300, avd_pkg::TT_BUY, 10'd50, 10'd51));
    trade_q.push_back(mk(24'd100, 24'hFF_FFFF, avd_pkg::TT_SELL, 10'd52, 10'd53));

    run_phase(300, 21, 85, 24'd500, 24'd1000);
    hold_req = 1'b1;
    run_phase(300, 85, 21, 24'd200, 24'd20000);
    run_phase(200, 0, 0, 24'd1500, 24'd5000);
    run_phase(200, 0, 0, 24'($urandom_range(3000, 0)), 24'($urandom_range(100000, 0)));
    drain();

    $display("Covered %0d trades and %0d alerts over %0d threshold writes,",
             trade_cnt, alert_cnt, wr_cnt);
    $display("with idle and stall patterns on both sides and one long output hold.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/avd_pkg.sv
hdl/avd_mul.sv
hdl/avd_div.sv
hdl/avd_dp.sv
hdl/avd_ctrl.sv
hdl/agent_vwap_deviation_alert_top.sv
test/tb_agent_vwap_deviation_alert_top.sv
